// File: rtl/core/mdpm_pkg.sv
package mdpm_pkg;

  // Datapath widths
  localparam int SAMPLE_BITS = 24;
  localparam int GAIN_BITS   = 16;
  localparam int NUM_SLOTS   = 5;
  localparam int SLOT_BITS   = $clog2(NUM_SLOTS);
  localparam int MODE_BITS   = 3;

  // Configuration channel
  localparam int CFG_INDEX_BITS = 8;
  localparam int CFG_DATA_BITS  = 32;

  localparam logic [CFG_INDEX_BITS-1:0] REG_CHANNEL_MODE   = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] REG_CENTRE_LEVEL   = CFG_INDEX_BITS'(1);
  localparam logic [CFG_INDEX_BITS-1:0] REG_SURROUND_LEVEL = CFG_INDEX_BITS'(2);

  // Coded channel layouts
  localparam logic [MODE_BITS-1:0] MODE_DUAL_MONO = 3'd0;
  localparam logic [MODE_BITS-1:0] MODE_1_0       = 3'd1;
  localparam logic [MODE_BITS-1:0] MODE_2_0       = 3'd2;
  localparam logic [MODE_BITS-1:0] MODE_3_0       = 3'd3;
  localparam logic [MODE_BITS-1:0] MODE_2_1       = 3'd4;
  localparam logic [MODE_BITS-1:0] MODE_3_1       = 3'd5;
  localparam logic [MODE_BITS-1:0] MODE_2_2       = 3'd6;
  localparam logic [MODE_BITS-1:0] MODE_3_2       = 3'd7;

  localparam logic [MODE_BITS-1:0] MODE_RESET  = MODE_2_0;
  localparam logic [GAIN_BITS-1:0] LEVEL_RESET = GAIN_BITS'(46341);

  // -3 dB in Q0.32 and +3 dB in Q2.30
  localparam logic [31:0] MINUS3_Q32 = 32'hB504_F334;
  localparam logic [31:0] PLUS3_Q30  = 32'd1518500250;

  localparam logic [32:0] M3_ROUNDED = {1'b0, MINUS3_Q32} + (33'd1 << (31 - GAIN_BITS));
  localparam logic [GAIN_BITS:0] M3_GAIN = (GAIN_BITS+1)'(M3_ROUNDED >> (32 - GAIN_BITS));
  localparam logic [GAIN_BITS:0] GAIN_UNITY = (GAIN_BITS+1)'(1) << GAIN_BITS;
  localparam logic [GAIN_BITS-1:0] GAIN_MAX = '1;

  // Largest magnitude the mix may report
  localparam logic [SAMPLE_BITS-1:0] PEAK_LIMIT = SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);

  typedef logic signed [SAMPLE_BITS-1:0]          sample_t;
  typedef logic [SAMPLE_BITS-1:0]                 level_t;
  typedef logic [GAIN_BITS-1:0]                   gain_t;
  typedef logic [NUM_SLOTS-1:0][GAIN_BITS-1:0]    gain_set_t;

endpackage

// File: rtl/core/mdpm_in_if.sv
interface mdpm_in_if import mdpm_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample_a;
  sample_t sample_b;
  sample_t sample_c;
  sample_t sample_d;
  sample_t sample_e;
  logic    final_sample;

  modport source (
    output valid, sample_a, sample_b, sample_c, sample_d, sample_e, final_sample,
    input  ready
  );
  modport sink (
    input  valid, sample_a, sample_b, sample_c, sample_d, sample_e, final_sample,
    output ready
  );
endinterface

// File: rtl/core/mdpm_out_if.sv
interface mdpm_out_if import mdpm_pkg::*; ();
  logic   valid;
  logic   ready;
  level_t peak_level;

  modport source (output valid, peak_level, input ready);
  modport sink (input valid, peak_level, output ready);
endinterface

// File: rtl/core/mdpm_cfg_if.sv
interface mdpm_cfg_if import mdpm_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_BITS-1:0] index;
  logic [CFG_DATA_BITS-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/core/mono_downmix_peak_meter_core.sv
// Channel  | Role | Transaction moves
// ---------+------+----------------------------------------------------------
// frame    | in   | sample_a..sample_e (signed Q1.23), final_sample
// peak     | out  | peak_level (Q1.23 magnitude), one per span, on its last item
// cfg      | in   | index 0 channel_mode, 1 centre_level, 2 surround_level
//
// One item is taken every cycle unless stalled; the output register holds each span's peak.
// The rate is set by the three-stage mix pipeline: input, products, magnitude.
// After reset and after each write to a known register the gain unit scales the levels,
// sums the gains and, if the sum tops unity, divides each by it; frame and cfg stall.
// A waiting result stalls a final item in stage 3 and the items behind it; items ahead flow.
// Reset is synchronous and restores the reset registers and clears the peak.
module mono_downmix_peak_meter_core import mdpm_pkg::*; (
  input logic        clk,
  input logic        rst,
  mdpm_in_if.sink    frame,
  mdpm_out_if.source peak,
  mdpm_cfg_if.sink   cfg
);

  localparam int PROD_BITS = SAMPLE_BITS + GAIN_BITS + 1;
  localparam int ACC_BITS  = SAMPLE_BITS + GAIN_BITS + 4;
  localparam int SHR_BITS  = ACC_BITS - GAIN_BITS;

  localparam logic [ACC_BITS-1:0] ROUND_HALF = ACC_BITS'(1) << (GAIN_BITS - 1);

  typedef logic signed [PROD_BITS-1:0] prod_t;

  logic      gains_busy;
  gain_set_t mix_gains;

  // Stage 1: registered input item
  logic    s1_v;
  sample_t s1_smp [NUM_SLOTS];
  logic    s1_final;
  // Stage 2: weighted channel products
  logic    s2_v;
  prod_t   s2_prod [NUM_SLOTS];
  logic    s2_final;
  // Stage 3: saturated mix magnitude
  logic    s3_v;
  level_t  s3_mag;
  logic    s3_final;

  level_t  running_peak;
  logic    out_valid;
  level_t  out_level;

  logic                       out_free;
  logic                       s3_go;
  logic                       s3_ready;
  logic                       s2_ready;
  logic                       s1_ready;
  logic                       in_take;
  logic signed [ACC_BITS-1:0] acc;
  logic [ACC_BITS-1:0]        abs_val;
  logic [ACC_BITS-1:0]        rnd_val;
  logic [SHR_BITS-1:0]        shr_val;
  level_t                     mag_sat;
  level_t                     peak_new;

  mdpm_gain_unit u_gain (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .busy      (gains_busy),
    .mix_gains (mix_gains)
  );

  // Flow control: only a final item waits on the output register
  assign out_free    = !out_valid || peak.ready;
  assign s3_go       = s3_v && (!s3_final || out_free);
  assign s3_ready    = !s3_v || s3_go;
  assign s2_ready    = !s2_v || s3_ready;
  assign s1_ready    = !s1_v || s2_ready;
  assign frame.ready = s1_ready && !gains_busy;
  assign in_take     = frame.valid && frame.ready;

  assign peak.valid      = out_valid;
  assign peak.peak_level = out_level;

  // Sum, magnitude, round half up, drop the gain fraction and saturate
  always_comb begin
    acc = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      acc = acc + ACC_BITS'(s2_prod[i]);
    end
    abs_val = acc[ACC_BITS-1] ? ACC_BITS'(-acc) : ACC_BITS'(acc);
    rnd_val = abs_val + ROUND_HALF;
    shr_val = rnd_val[ACC_BITS-1:GAIN_BITS];
    mag_sat = (shr_val > SHR_BITS'(PEAK_LIMIT)) ? PEAK_LIMIT : shr_val[SAMPLE_BITS-1:0];
  end

  assign peak_new = (s3_mag > running_peak) ? s3_mag : running_peak;

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v         <= 1'b0;
      s2_v         <= 1'b0;
      s3_v         <= 1'b0;
      out_valid    <= 1'b0;
      running_peak <= '0;
    end else begin
      if (s1_ready) begin
        s1_v <= in_take;
      end
      if (s2_ready) begin
        s2_v <= s1_v;
      end
      if (s3_ready) begin
        s3_v <= s2_v;
      end
      // Load a new result on a final item, else drop the delivered one
      if (s3_go && s3_final) begin
        out_valid <= 1'b1;
      end else if (peak.ready) begin
        out_valid <= 1'b0;
      end
      if (s3_go) begin
        if (s3_final) begin
          running_peak <= '0;
        end else begin
          running_peak <= peak_new;
        end
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_smp[0] <= frame.sample_a;
      s1_smp[1] <= frame.sample_b;
      s1_smp[2] <= frame.sample_c;
      s1_smp[3] <= frame.sample_d;
      s1_smp[4] <= frame.sample_e;
      s1_final  <= frame.final_sample;
    end
    if (s2_ready && s1_v) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        s2_prod[i] <= s1_smp[i] * $signed({1'b0, mix_gains[i]});
      end
      s2_final <= s1_final;
    end
    if (s3_ready && s2_v) begin
      s3_mag   <= mag_sat;
      s3_final <= s2_final;
    end
    if (s3_go && s3_final) begin
      out_level <= peak_new;
    end
  end

  a_no_take_while_deriving: assert property (@(posedge clk) disable iff (rst)
    gains_busy |-> !frame.ready)
    else $error("item accepted while gains are being derived");

  a_peak_bounded: assert property (@(posedge clk) disable iff (rst)
    running_peak <= PEAK_LIMIT)
    else $error("running peak above full scale");

  a_final_delivers: assert property (@(posedge clk) disable iff (rst)
    (s3_go && s3_final) |=> (peak.valid && peak.peak_level == $past(peak_new)))
    else $error("final item did not load the span peak");

  a_peak_tracks: assert property (@(posedge clk) disable iff (rst)
    (s3_go && !s3_final) |=> (running_peak == $past(peak_new)))
    else $error("running peak not updated");

endmodule

// File: rtl/core/mdpm_gain_unit.sv
module mdpm_gain_unit import mdpm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  mdpm_cfg_if.sink   cfg,
  output logic       busy,
  output gain_set_t  mix_gains
);

  localparam int SUM_BITS  = GAIN_BITS + 4;
  localparam int REM_BITS  = 2 * GAIN_BITS + 4;
  localparam int STEP_BITS = $clog2(GAIN_BITS + 1);
  localparam int MUL_BITS  = GAIN_BITS + 32;

  localparam logic [MUL_BITS:0] CEN_HALF = (MUL_BITS+1)'(1) << 29;
  localparam logic [MUL_BITS:0] SUR_HALF = (MUL_BITS+1)'(1) << 31;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CEN  = 3'd1;
  localparam logic [2:0] ST_SUR  = 3'd2;
  localparam logic [2:0] ST_SUM  = 3'd3;
  localparam logic [2:0] ST_LOAD = 3'd4;
  localparam logic [2:0] ST_DIV  = 3'd5;

  typedef logic [GAIN_BITS:0] wide_gain_t;

  logic [2:0]           state;
  logic [MODE_BITS-1:0] channel_mode;
  gain_t                centre_level;
  gain_t                surround_level;
  wide_gain_t           cen_gain;
  gain_t                sur_gain;
  wide_gain_t           wgain [NUM_SLOTS];
  logic [SUM_BITS-1:0]  gain_sum;
  logic [SLOT_BITS-1:0] slot;
  logic [STEP_BITS-1:0] step;
  logic [REM_BITS-1:0]  rem;
  logic [REM_BITS-1:0]  dsh;
  wide_gain_t           quot;

  gain_t                mul_a;
  logic [31:0]          mul_b;
  logic [MUL_BITS-1:0]  mul_prod;
  logic [MUL_BITS:0]    cen_rnd;
  logic [MUL_BITS:0]    sur_rnd;
  wide_gain_t           g_sel [NUM_SLOTS];
  logic [SUM_BITS-1:0]  sum_sel;
  logic                 div_ge;
  wide_gain_t           quot_next;

  function automatic gain_t sat_gain(input wide_gain_t g);
    return g[GAIN_BITS] ? GAIN_MAX : g[GAIN_BITS-1:0];
  endfunction

  // One multiplier, shared by the centre and surround scaling
  assign mul_a    = (state == ST_CEN) ? centre_level : surround_level;
  assign mul_b    = (state == ST_CEN) ? PLUS3_Q30 : MINUS3_Q32;
  assign mul_prod = mul_a * mul_b;
  assign cen_rnd  = {1'b0, mul_prod} + CEN_HALF;
  assign sur_rnd  = {1'b0, mul_prod} + SUR_HALF;

  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      g_sel[i] = '0;
    end
    case (channel_mode)
      MODE_DUAL_MONO: begin
      end
      MODE_1_0: begin
        g_sel[0] = GAIN_UNITY;
      end
      MODE_2_0: begin
        g_sel[0] = M3_GAIN;
        g_sel[1] = M3_GAIN;
      end
      MODE_3_0: begin
        g_sel[0] = M3_GAIN;
        g_sel[1] = cen_gain;
        g_sel[2] = M3_GAIN;
      end
      MODE_2_1: begin
        g_sel[0] = M3_GAIN;
        g_sel[1] = M3_GAIN;
        g_sel[2] = {1'b0, sur_gain};
      end
      MODE_3_1: begin
        g_sel[0] = M3_GAIN;
        g_sel[1] = cen_gain;
        g_sel[2] = M3_GAIN;
        g_sel[3] = {1'b0, sur_gain};
      end
      MODE_2_2: begin
        g_sel[0] = M3_GAIN;
        g_sel[1] = M3_GAIN;
        g_sel[2] = {1'b0, sur_gain};
        g_sel[3] = {1'b0, sur_gain};
      end
      MODE_3_2: begin
        g_sel[0] = M3_GAIN;
        g_sel[1] = cen_gain;
        g_sel[2] = M3_GAIN;
        g_sel[3] = {1'b0, sur_gain};
        g_sel[4] = {1'b0, sur_gain};
      end
      default: begin
      end
    endcase
    sum_sel = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      sum_sel = sum_sel + SUM_BITS'(g_sel[i]);
    end
  end

  // Restoring division, one quotient bit a cycle
  assign div_ge    = (rem >= dsh);
  assign quot_next = {quot[GAIN_BITS-1:0], div_ge};

  assign busy      = (state != ST_IDLE);
  assign cfg.ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_CEN;
      channel_mode   <= MODE_RESET;
      centre_level   <= LEVEL_RESET;
      surround_level <= LEVEL_RESET;
    end else begin
      case (state)
        ST_IDLE: begin
          if (cfg.valid) begin
            case (cfg.index)
              REG_CHANNEL_MODE: begin
                channel_mode <= cfg.data[MODE_BITS-1:0];
                state        <= ST_CEN;
              end
              REG_CENTRE_LEVEL: begin
                centre_level <= cfg.data[GAIN_BITS-1:0];
                state        <= ST_CEN;
              end
              REG_SURROUND_LEVEL: begin
                surround_level <= cfg.data[GAIN_BITS-1:0];
                state          <= ST_CEN;
              end
              default: begin
              end
            endcase
          end
        end
        ST_CEN:  state <= ST_SUR;
        ST_SUR:  state <= ST_SUM;
        ST_SUM:  state <= (sum_sel > SUM_BITS'(GAIN_UNITY)) ? ST_LOAD : ST_IDLE;
        ST_LOAD: state <= ST_DIV;
        ST_DIV: begin
          if (step == STEP_BITS'(GAIN_BITS)) begin
            state <= (slot == SLOT_BITS'(NUM_SLOTS - 1)) ? ST_IDLE : ST_LOAD;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_CEN: cen_gain <= cen_rnd[30 +: GAIN_BITS+1];
      ST_SUR: sur_gain <= sur_rnd[32 +: GAIN_BITS];
      ST_SUM: begin
        gain_sum <= sum_sel;
        slot     <= '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
          wgain[i] <= g_sel[i];
        end
        if (sum_sel <= SUM_BITS'(GAIN_UNITY)) begin
          for (int i = 0; i < NUM_SLOTS; i++) begin
            mix_gains[i] <= sat_gain(g_sel[i]);
          end
        end
      end
      ST_LOAD: begin
        rem  <= (REM_BITS'(wgain[slot]) << GAIN_BITS) + REM_BITS'(gain_sum >> 1);
        dsh  <= REM_BITS'(gain_sum) << GAIN_BITS;
        quot <= '0;
        step <= '0;
      end
      ST_DIV: begin
        if (div_ge) begin
          rem <= rem - dsh;
        end
        dsh  <= dsh >> 1;
        quot <= quot_next;
        step <= step + STEP_BITS'(1);
        if (step == STEP_BITS'(GAIN_BITS)) begin
          mix_gains[slot] <= sat_gain(quot_next);
          slot            <= slot + SLOT_BITS'(1);
        end
      end
      default: begin
      end
    endcase
  end

  a_busy_after_reset: assert property (@(posedge clk) rst |=> busy)
    else $error("gain derivation not started after reset");

  a_busy_after_write: assert property (@(posedge clk) disable iff (rst)
    (cfg.valid && cfg.ready && (cfg.index == REG_CHANNEL_MODE ||
      cfg.index == REG_CENTRE_LEVEL || cfg.index == REG_SURROUND_LEVEL)) |=> busy)
    else $error("register write did not start gain derivation");

  a_div_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> ({1'b0, rem} < {dsh, 1'b0}))
    else $error("division remainder out of range");

endmodule

// File: verif/tb_mono_downmix_peak_meter_core.sv
module tb_mono_downmix_peak_meter_core import mdpm_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CYCLE_LIMIT     = 500000;
  localparam int          SETTLE_CYCLES   = 8;
  localparam int          HOLD_OFF_CYCLES = 300;
  localparam int          MAX_IDLE        = 13;

  localparam sample_t     FULL_POS = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam sample_t     FULL_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam longint unsigned PEAK_CAP   = 64'd1 << (SAMPLE_BITS - 1);
  localparam longint unsigned UNITY_GAIN = 64'd1 << GAIN_BITS;

  // First index past the register list; writes there must be ignored
  localparam logic [CFG_INDEX_BITS-1:0] FIRST_UNUSED_INDEX = REG_SURROUND_LEVEL + 1'b1;

  // One sample instant as offered on the frame channel
  typedef struct {
    sample_t smp [NUM_SLOTS];
    logic    fin;
  } frame_t;

  logic clk = 1'b0;
  logic rst;

  mdpm_in_if  frame_if ();
  mdpm_out_if peak_if ();
  mdpm_cfg_if cfg_if ();

  mono_downmix_peak_meter_core uut (
    .clk   (clk),
    .rst   (rst),
    .frame (frame_if),
    .peak  (peak_if),
    .cfg   (cfg_if)
  );

  always #6 clk = ~clk;

  // Predictor state: registers as written, derived gains and the open span's peak
  logic [MODE_BITS-1:0] cur_mode;
  gain_t                cur_centre;
  gain_t                cur_surround;
  gain_t                mix_gain [NUM_SLOTS];
  level_t               peak_so_far;
  level_t               peak_expected [$];

  int    mismatches = 0;
  int    cycle_count = 0;
  bit    source_gaps;
  bit    sink_stalls;
  bit    hold_off_pending = 1'b0;
  level_t peak_want;

  // ---------------------------------------------------------------------------
  // Gain derivation: -3 dB on L/R, centre_level +3 dB on C (unity for 1/0),
  // surround_level -3 dB on each surround, then normalise if the sum tops unity.
  // ---------------------------------------------------------------------------
  function automatic void recompute_mix_gains();
    longint unsigned g [NUM_SLOTS];
    longint unsigned m3, cen, sur, total;
    m3  = (64'(MINUS3_Q32) + (64'd1 << (31 - GAIN_BITS))) >> (32 - GAIN_BITS);
    cen = (64'(cur_centre) * 64'(PLUS3_Q30) + (64'd1 << 29)) >> 30;
    sur = (64'(cur_surround) * 64'(MINUS3_Q32) + (64'd1 << 31)) >> 32;
    for (int i = 0; i < NUM_SLOTS; i++) g[i] = 0;
    case (cur_mode)
      MODE_1_0: g[0] = UNITY_GAIN;
      MODE_2_0: begin
        g[0] = m3; g[1] = m3;
      end
      MODE_3_0: begin
        g[0] = m3; g[1] = cen; g[2] = m3;
      end
      MODE_2_1: begin
        g[0] = m3; g[1] = m3; g[2] = sur;
      end
      MODE_3_1: begin
        g[0] = m3; g[1] = cen; g[2] = m3; g[3] = sur;
      end
      MODE_2_2: begin
        g[0] = m3; g[1] = m3; g[2] = sur; g[3] = sur;
      end
      MODE_3_2: begin
        g[0] = m3; g[1] = cen; g[2] = m3; g[3] = sur; g[4] = sur;
      end
      default: ;  // dual mono folds to silence
    endcase
    total = 0;
    for (int i = 0; i < NUM_SLOTS; i++) total += g[i];
    if (total > UNITY_GAIN)
      for (int i = 0; i < NUM_SLOTS; i++)
        g[i] = ((g[i] << GAIN_BITS) + (total >> 1)) / total;
    // A gain of exactly unity does not fit; clamp to the top code
    for (int i = 0; i < NUM_SLOTS; i++)
      mix_gain[i] = (g[i] > 64'(GAIN_MAX)) ? GAIN_MAX : gain_t'(g[i]);
  endfunction

  function automatic void reset_predictor();
    cur_mode     = MODE_RESET;
    cur_centre   = LEVEL_RESET;
    cur_surround = LEVEL_RESET;
    peak_so_far  = '0;
    recompute_mix_gains();
  endfunction

  function automatic void apply_register(input logic [CFG_INDEX_BITS-1:0] idx,
                                         input logic [CFG_DATA_BITS-1:0] value);
    bit known;
    known = 1'b1;
    case (idx)
      REG_CHANNEL_MODE:   cur_mode     = value[MODE_BITS-1:0];
      REG_CENTRE_LEVEL:   cur_centre   = value[GAIN_BITS-1:0];
      REG_SURROUND_LEVEL: cur_surround = value[GAIN_BITS-1:0];
      default:            known = 1'b0;
    endcase
    if (known) recompute_mix_gains();
  endfunction

  // Fold one instant to mono, round and clamp its magnitude, and update the span peak.
  // A final instant closes the span: queue its peak and clear.
  function automatic void track_peak(input frame_t f);
    longint          acc;
    longint unsigned mag;
    acc = 0;
    for (int i = 0; i < NUM_SLOTS; i++)
      acc += longint'(f.smp[i]) * longint'(mix_gain[i]);
    if (acc < 0) acc = -acc;
    mag = acc;
    mag = (mag + (64'd1 << (GAIN_BITS - 1))) >> GAIN_BITS;
    if (mag > PEAK_CAP) mag = PEAK_CAP;
    if (mag > 64'(peak_so_far)) peak_so_far = level_t'(mag);
    if (f.fin) begin
      peak_expected.push_back(peak_so_far);
      peak_so_far = '0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Channel drivers. Handshakes are sampled on the falling edge, where valid and
  // ready are both settled, and the transaction completes on the next rising edge.
  // ---------------------------------------------------------------------------
  task automatic send_frame(input frame_t f);
    if (source_gaps && $urandom_range(0, 4) == 0) begin
      frame_if.valid <= 1'b0;
      repeat ($urandom_range(1, MAX_IDLE)) @(posedge clk);
    end
    frame_if.valid        <= 1'b1;
    frame_if.sample_a     <= f.smp[0];
    frame_if.sample_b     <= f.smp[1];
    frame_if.sample_c     <= f.smp[2];
    frame_if.sample_d     <= f.smp[3];
    frame_if.sample_e     <= f.smp[4];
    frame_if.final_sample <= f.fin;
    @(negedge clk);
    while (!frame_if.ready) @(negedge clk);
    @(posedge clk);
    track_peak(f);
  endtask

  // Drop valid, let every expected peak arrive, then give the pipeline time to empty
  // of non-final instants still in flight.
  task automatic wait_idle();
    frame_if.valid <= 1'b0;
    while (peak_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] value);
    wait_idle();
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    @(negedge clk);
    while (!cfg_if.ready) @(negedge clk);
    @(posedge clk);
    cfg_if.valid <= 1'b0;
    apply_register(idx, value);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic int slots_in_layout(input logic [MODE_BITS-1:0] mode);
    case (mode)
      MODE_1_0:           return 1;
      MODE_DUAL_MONO,
      MODE_2_0:           return 2;
      MODE_3_0, MODE_2_1: return 3;
      MODE_3_1, MODE_2_2: return 4;
      default:            return 5;
    endcase
  endfunction

  function automatic sample_t pick_sample();
    case ($urandom_range(0, 9))
      0:       return FULL_POS;
      1:       return FULL_NEG;
      2:       return sample_t'($urandom_range(0, 511)) - sample_t'(256);
      default: return sample_t'($urandom());
    endcase
  endfunction

  function automatic frame_t uniform_frame(input sample_t v, input logic fin);
    frame_t f;
    for (int i = 0; i < NUM_SLOTS; i++) f.smp[i] = v;
    f.fin = fin;
    return f;
  endfunction

  // Mostly well-formed: slots the layout lacks carry zero. Now and then fill them
  // with noise, which the zero gains must swallow.
  function automatic frame_t random_frame(input int final_odds);
    frame_t f;
    int     used;
    bit     tidy;
    used = slots_in_layout(cur_mode);
    tidy = ($urandom_range(0, 4) != 0);
    for (int i = 0; i < NUM_SLOTS; i++)
      f.smp[i] = (tidy && i >= used) ? sample_t'(0) : pick_sample();
    f.fin = ($urandom_range(1, final_odds) == 1);
    return f;
  endfunction

  function automatic logic [CFG_DATA_BITS-1:0] pick_level();
    logic [CFG_DATA_BITS-1:0] v;
    v = $urandom();
    case ($urandom_range(0, 3))
      0:       v[GAIN_BITS-1:0] = '0;
      1:       v[GAIN_BITS-1:0] = GAIN_MAX;
      default: ;
    endcase
    if ($urandom_range(0, 1)) v[CFG_DATA_BITS-1:GAIN_BITS] = '0;
    return v;
  endfunction

  function automatic logic [CFG_DATA_BITS-1:0] pick_mode();
    logic [CFG_DATA_BITS-1:0] v;
    v = $urandom();
    if ($urandom_range(0, 1)) v[CFG_DATA_BITS-1:MODE_BITS] = '0;
    return v;
  endfunction

  task automatic shuffle_config();
    int writes;
    writes = $urandom_range(1, 3);
    repeat (writes) begin
      case ($urandom_range(0, 6))
        0, 1:    write_reg(REG_CHANNEL_MODE, pick_mode());
        2, 3:    write_reg(REG_CENTRE_LEVEL, pick_level());
        4, 5:    write_reg(REG_SURROUND_LEVEL, pick_level());
        default: write_reg(CFG_INDEX_BITS'($urandom_range(FIRST_UNUSED_INDEX, 255)),
                           $urandom());
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset layout is 2/0 with both levels at -3 dB; full-scale stereo folds to unity
  task automatic test_reset_defaults();
    send_frame(uniform_frame(FULL_POS, 1'b0));
    send_frame(uniform_frame(FULL_NEG, 1'b1));
    send_frame(uniform_frame(sample_t'(0), 1'b1));
  endtask

  // Visit every layout with full-scale instants; dual mono must read zero and
  // 1/0 exercises the clamped unity centre gain
  task automatic test_each_layout();
    for (int m = 0; m < (1 << MODE_BITS); m++) begin
      write_reg(REG_CHANNEL_MODE, CFG_DATA_BITS'(m));
      send_frame(uniform_frame(FULL_POS, 1'b0));
      send_frame(uniform_frame(FULL_NEG, 1'b1));
    end
  endtask

  // Level extremes on the full 3/2 layout, upper data bits masked off, and writes
  // beyond the register list left without effect
  task automatic test_level_extremes();
    write_reg(REG_CENTRE_LEVEL, {{(CFG_DATA_BITS-GAIN_BITS){1'b1}}, {GAIN_BITS{1'b0}}});
    write_reg(REG_SURROUND_LEVEL, CFG_DATA_BITS'(GAIN_MAX));
    send_frame(uniform_frame(FULL_NEG, 1'b1));
    write_reg(REG_CENTRE_LEVEL, {CFG_DATA_BITS{1'b1}});
    write_reg(REG_SURROUND_LEVEL, '0);
    send_frame(uniform_frame(FULL_POS, 1'b1));
    write_reg(FIRST_UNUSED_INDEX, {CFG_DATA_BITS{1'b1}});
    write_reg({CFG_INDEX_BITS{1'b1}}, '0);
    write_reg(REG_CHANNEL_MODE, {{(CFG_DATA_BITS-MODE_BITS){1'b1}}, MODE_3_1});
    send_frame(uniform_frame(FULL_NEG, 1'b0));
    send_frame(uniform_frame(FULL_POS, 1'b1));
  endtask

  // Random settings, each followed by a run of instants with spans of varied length
  task automatic test_random_spans();
    int odds;
    for (int phase = 0; phase < 10; phase++) begin
      shuffle_config();
      case ($urandom_range(0, 2))
        0:       odds = 2;
        1:       odds = 8;
        default: odds = 30;
      endcase
      repeat (125) send_frame(random_frame(odds));
    end
  endtask

  // Hold the peak channel off for a long stretch while final instants keep coming,
  // so a waiting result backs up into the frame channel
  task automatic test_output_backpressure();
    wait_idle();
    source_gaps = 1'b0;
    hold_off_pending = 1'b1;
    repeat (64) send_frame(random_frame(2));
    source_gaps = 1'b1;
  endtask

  // Last stretch: no idling on either side, back-to-back transactions
  task automatic test_steady_stream();
    wait_idle();
    write_reg(REG_CHANNEL_MODE, CFG_DATA_BITS'(MODE_3_2));
    write_reg(REG_CENTRE_LEVEL, pick_level());
    write_reg(REG_SURROUND_LEVEL, pick_level());
    source_gaps = 1'b0;
    sink_stalls = 1'b0;
    repeat (400) send_frame(random_frame(6));
  endtask

  // ---------------------------------------------------------------------------
  // Peak receiver: random stalls, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    peak_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_pending) begin
        hold_off_pending = 1'b0;
        peak_if.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
        peak_if.ready <= 1'b0;
        repeat ($urandom_range(1, MAX_IDLE)) @(posedge clk);
      end
      peak_if.ready <= 1'b1;
    end
  end

  // Compare each peak transaction with the oldest expected span peak
  always @(negedge clk) begin
    if (!rst && peak_if.valid && peak_if.ready) begin
      if (peak_expected.size() == 0) begin
        $error("peak_level: no result expected, actual %0d", peak_if.peak_level);
        mismatches++;
      end else begin
        peak_want = peak_expected.pop_front();
        if (peak_if.peak_level !== peak_want) begin
          $error("peak_level: expected %0d, actual %0d", peak_want, peak_if.peak_level);
          mismatches++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    rst                   = 1'b1;
    frame_if.valid        = 1'b0;
    frame_if.sample_a     = '0;
    frame_if.sample_b     = '0;
    frame_if.sample_c     = '0;
    frame_if.sample_d     = '0;
    frame_if.sample_e     = '0;
    frame_if.final_sample = 1'b0;
    cfg_if.valid          = 1'b0;
    cfg_if.index          = '0;
    cfg_if.data           = '0;
    source_gaps           = 1'b1;
    sink_stalls           = 1'b1;
    reset_predictor();

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_each_layout();
    test_level_extremes();
    test_random_spans();
    test_output_backpressure();
    test_steady_stream();

    // Drain: every expected peak in, then a settling wait for stray output
    wait_idle();
    if (peak_expected.size() == 0 && mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

// File: sim.f
rtl/core/mdpm_pkg.sv
rtl/core/mdpm_in_if.sv
rtl/core/mdpm_out_if.sv
rtl/core/mdpm_cfg_if.sv
rtl/core/mdpm_gain_unit.sv
rtl/core/mono_downmix_peak_meter_core.sv
verif/tb_mono_downmix_peak_meter_core.sv
